### sv/imwm_pkg.sv
`timescale 1ns / 1ps
// Package with the shared constants, decode codes and result types of the immediate ALU core.
package imwm_pkg;

    localparam int NUM_GP_REGS = 31;
    localparam int GPR_AW      = $clog2(NUM_GP_REGS);

    localparam logic [4:0]  REG_SP_ZR   = 5'h1F;
    localparam logic [2:0]  CLS_ADDSUB  = 3'h2;
    localparam logic [2:0]  CLS_WIDEMOV = 3'h5;
    localparam logic [1:0]  OPC_MOVN    = 2'h0;
    localparam logic [1:0]  OPC_BAD     = 2'h1;
    localparam logic [1:0]  OPC_MOVZ    = 2'h2;
    localparam logic [1:0]  OPC_MOVK    = 2'h3;
    localparam logic [63:0] MASK_W32    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] HALF_MASK   = 64'h0000_0000_0000_FFFF;
    localparam int          IMM_SHIFT   = 12;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic        handled;
        logic        we;
        logic        to_sp;
        logic [4:0]  dest;
        logic [63:0] value;
        t_flags      flags;
    } t_exec_res;

endpackage

### sv/imwm_regfile.sv
`timescale 1ns / 1ps
// General register file: synchronous memory with registered read and per-entry valid bits.
module imwm_regfile
    import imwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_rd_idx,
    output logic [63:0] o_rd_data,
    input  logic        i_wr_en,
    input  logic [4:0]  i_wr_idx,
    input  logic [63:0] i_wr_data
);

    logic [63:0]            r_mem [NUM_GP_REGS];
    logic [NUM_GP_REGS-1:0] r_valid;
    logic [63:0]            r_rd_data;
    logic                   r_rd_hit;
    logic                   rd_in_range;
    logic                   wr_in_range;

    assign rd_in_range = (i_rd_idx < 5'(NUM_GP_REGS));
    assign wr_in_range = (i_wr_idx < 5'(NUM_GP_REGS));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_mem[i_wr_idx[GPR_AW-1:0]] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx[GPR_AW-1:0]];
        end
    end

    // An entry never written since reset, or an index past the file, reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && wr_in_range) begin
                r_valid[i_wr_idx[GPR_AW-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= rd_in_range && r_valid[i_rd_idx[GPR_AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 64'd0;

endmodule

### sv/imwm_exec.sv
`timescale 1ns / 1ps
// Execute logic: decodes one instruction word and forms the result, write-back and flags.
module imwm_exec
    import imwm_pkg::*;
(
    input  logic [31:0] i_instr,
    input  logic [63:0] i_gpr,
    input  logic [63:0] i_sp,
    input  t_flags      i_flags,
    output t_exec_res   o_res
);

    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [2:0]  cls;
    logic [1:0]  opc;
    logic        sf;
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] op2;
    logic [64:0] sum;
    logic [63:0] res;
    logic        sa;
    logic        so;
    logic        sr;
    logic [5:0]  shift;
    logic [63:0] wide_op;
    logic [63:0] wide_res;
    logic        rd_ok;

    assign rd    = i_instr[4:0];
    assign rn    = i_instr[9:5];
    assign cls   = i_instr[25:23];
    assign opc   = i_instr[30:29];
    assign sf    = i_instr[31];
    assign mask  = sf ? '1 : MASK_W32;
    assign rd_ok = (rd != REG_SP_ZR) && (rd < 5'(NUM_GP_REGS));

    assign op2 = i_instr[22] ? (64'(i_instr[21:10]) << IMM_SHIFT) : 64'(i_instr[21:10]);
    assign a   = ((rn == REG_SP_ZR) ? i_sp : i_gpr) & mask;
    assign sum = opc[1] ? ({1'b0, a} - {1'b0, op2}) : ({1'b0, a} + {1'b0, op2});
    assign res = sum[63:0] & mask;
    assign sa  = sf ? a[63] : a[31];
    assign so  = sf ? op2[63] : op2[31];
    assign sr  = sf ? res[63] : res[31];

    assign shift    = {i_instr[22:21], 4'd0};
    assign wide_op  = 64'(i_instr[20:5]) << shift;

    always_comb begin
        case (opc)
            OPC_MOVN: wide_res = ~wide_op;
            OPC_MOVZ: wide_res = wide_op;
            OPC_MOVK: wide_res = ((i_gpr & mask) & ~(HALF_MASK << shift)) | wide_op;
            default:  wide_res = 64'd0;
        endcase
    end

    always_comb begin
        o_res         = '0;
        o_res.flags   = i_flags;
        if (cls == CLS_ADDSUB) begin
            o_res.handled = 1'b1;
            if (opc[0]) begin
                o_res.flags.n = sr;
                o_res.flags.z = (res == 64'd0);
                if (opc[1]) begin
                    // The top bit of the 65-bit difference is the borrow.
                    o_res.flags.c = !sum[64];
                    o_res.flags.v = (sa != so) && (sr != sa);
                end else begin
                    o_res.flags.c = sf ? sum[64] : sum[32];
                    o_res.flags.v = (sa == so) && (sr != sa);
                end
            end
            if (rd == REG_SP_ZR) begin
                o_res.we    = !opc[0];
                o_res.to_sp = !opc[0];
            end else begin
                o_res.we = rd_ok;
            end
            if (o_res.we) begin
                o_res.dest  = rd;
                o_res.value = res;
            end
        end else if (cls == CLS_WIDEMOV && opc != OPC_BAD) begin
            o_res.handled = 1'b1;
            o_res.we      = rd_ok;
            if (rd_ok) begin
                o_res.dest  = rd;
                o_res.value = wide_res & mask;
            end
        end
    end

endmodule

### sv/immediate_alu_and_wide_move_core.sv
`timescale 1ns / 1ps
// Top level of the immediate ALU and wide move core.
// One instruction word is accepted per cycle unless the input stalls, and its result is loaded
// into the output register when the execute stage advances: the accepting edge reads the
// general register file (a synchronous memory with registered read), and the advancing edge
// executes, writes back and loads the output register. A result written by one instruction is
// forwarded to the next one that reads the same register, so dependent instructions also run
// back to back. The stack pointer and the flags live in flip-flops. The input stalls only
// while the output register holds an untaken result and the execute stage is full.
module immediate_alu_and_wide_move_core
    import imwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_handled,
    output logic        o_write_enable,
    output logic [4:0]  o_dest_index,
    output logic [63:0] o_write_value,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_c,
    output logic        o_flag_v
);

    logic        r_s1_valid;
    logic [31:0] r_s1_instr;
    logic        r_fwd_hit;
    logic [63:0] r_fwd_val;
    logic [63:0] r_sp;
    t_flags      r_flags;
    logic        r_out_valid;
    t_exec_res   r_out;

    logic        accept;
    logic        advance;
    logic [4:0]  rd_idx;
    logic [63:0] rf_data;
    logic [63:0] gpr_op;
    t_exec_res   exec_res;
    logic        wr_gpr;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Wide moves read their destination (for movk); add/sub reads its source.
    assign rd_idx = (i_instr_word[25:23] == CLS_WIDEMOV) ? i_instr_word[4:0] : i_instr_word[9:5];
    assign wr_gpr = advance && exec_res.we && !exec_res.to_sp;

    imwm_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rf_data),
        .i_wr_en   (wr_gpr),
        .i_wr_idx  (exec_res.dest),
        .i_wr_data (exec_res.value)
    );

    assign gpr_op = r_fwd_hit ? r_fwd_val : rf_data;

    imwm_exec u_exec (
        .i_instr (r_s1_instr),
        .i_gpr   (gpr_op),
        .i_sp    (r_sp),
        .i_flags (r_flags),
        .o_res   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sp        <= 64'd0;
            r_flags     <= '0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                // The memory returns the old entry when it is written at the read edge.
                r_fwd_hit  <= wr_gpr && (exec_res.dest == rd_idx);
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= exec_res.flags;
                if (exec_res.we && exec_res.to_sp) begin
                    r_sp <= exec_res.value;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_instr <= i_instr_word;
            r_fwd_val  <= exec_res.value;
        end
        if (advance) begin
            r_out <= exec_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_handled      = r_out.handled;
    assign o_write_enable = r_out.we;
    assign o_dest_index   = r_out.dest;
    assign o_write_value  = r_out.value;
    assign o_flag_n       = r_out.flags.n;
    assign o_flag_z       = r_out.flags.z;
    assign o_flag_c       = r_out.flags.c;
    assign o_flag_v       = r_out.flags.v;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |=> r_s1_valid && $stable(r_s1_instr))
        else $error("execute stage lost a held instruction");

    a_unhandled_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.handled |-> !r_out.we)
        else $error("unhandled instruction reported a write");

    a_sp_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.we && r_out.to_sp && $rose(r_out_valid) |->
            r_sp == r_out.value)
        else $error("stack pointer does not match reported write");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.we |-> r_out.dest == 5'd0 && r_out.value == 64'd0)
        else $error("result without write carries nonzero index or value");

endmodule
